[src/fcsg_pkg.sv]
// ----------------------------------------------------------------------------
// fcsg_pkg
// Shared types, constants and codes of the filled-circle span generator.
// ----------------------------------------------------------------------------
package fcsg_pkg;

  localparam int RADIUS_BITS = 10;
  localparam int COORD_BITS  = 16;
  localparam int COLOR_BITS  = 16;
  localparam int LEN_BITS    = RADIUS_BITS + 1;
  localparam int SQ_BITS     = 2 * RADIUS_BITS;

  localparam int LIMIT_NUM   = 707;
  localparam int LIMIT_DEN   = 1000;
  localparam int LIMIT_SHIFT = RADIUS_BITS + 8;
  localparam longint unsigned LIMIT_MUL =
    (longint'(LIMIT_NUM) << LIMIT_SHIFT) / longint'(LIMIT_DEN);

  localparam logic OP_START = 1'b0;
  localparam logic OP_NEXT  = 1'b1;

  typedef logic [RADIUS_BITS-1:0] radius_t;
  typedef logic [COORD_BITS-1:0]  coord_t;
  typedef logic [COLOR_BITS-1:0]  color_t;
  typedef logic [LEN_BITS-1:0]    len_t;
  typedef logic [SQ_BITS-1:0]     sq_t;

  typedef enum logic [3:0] {
    PH_TEST     = 4'b0001,
    PH_OUTER_HI = 4'b0010,
    PH_INNER_LO = 4'b0100,
    PH_INNER_HI = 4'b1000
  } phase_t;

  typedef struct packed {
    logic    op;
    coord_t  center_x;
    coord_t  center_y;
    radius_t radius;
    color_t  fill_color;
  } in_item_t;

  typedef struct packed {
    logic   span_valid;
    coord_t span_x;
    coord_t span_y;
    len_t   span_length;
    color_t span_color;
  } out_item_t;

  typedef struct packed {
    logic    active;
    phase_t  phase;
    coord_t  cx;
    coord_t  cy;
    color_t  color;
    radius_t row_step;
    radius_t col_ext;
    radius_t row_limit;
    sq_t     dist_limit;
    sq_t     isq;
    sq_t     xsq;
  } circ_state_t;

endpackage

[src/fcsg_setup.sv]
// ----------------------------------------------------------------------------
// fcsg_setup
// Start decode: row limit, distance limit, squares and the center-row span.
// ----------------------------------------------------------------------------
module fcsg_setup
  import fcsg_pkg::*;
(
  input  in_item_t    item,
  output circ_state_t start_state,
  output out_item_t   start_span
);

  localparam int PROD_W = RADIUS_BITS + LIMIT_SHIFT;
  localparam int REM_W  = RADIUS_BITS + 11;

  radius_t            r;
  sq_t                rr;
  logic [PROD_W-1:0]  prod;
  radius_t            q0;
  logic [REM_W-1:0]   scaled;
  logic [REM_W-1:0]   back;
  logic [REM_W-1:0]   rem;
  radius_t            q;

  assign r      = item.radius;
  assign rr     = SQ_BITS'(r) * SQ_BITS'(r);
  assign prod   = PROD_W'(r) * PROD_W'(LIMIT_MUL);
  assign q0     = prod[PROD_W-1:LIMIT_SHIFT];
  assign scaled = REM_W'(r) * REM_W'(LIMIT_NUM);
  assign back   = REM_W'(q0) * REM_W'(LIMIT_DEN);
  assign rem    = scaled - back;
  assign q      = (rem >= REM_W'(LIMIT_DEN)) ? q0 + 1'b1 : q0;

  always_comb begin
    start_state            = '0;
    start_state.active     = (r != '0);
    start_state.phase      = PH_TEST;
    start_state.cx         = item.center_x;
    start_state.cy         = item.center_y;
    start_state.color      = item.fill_color;
    start_state.row_step   = RADIUS_BITS'(1);
    start_state.col_ext    = r;
    start_state.row_limit  = q + 1'b1;
    start_state.dist_limit = rr + SQ_BITS'(r >> 1);
    start_state.isq        = SQ_BITS'(1);
    start_state.xsq        = rr;

    start_span = '0;
    if (r != '0) begin
      start_span.span_valid  = 1'b1;
      start_span.span_x      = item.center_x - COORD_BITS'(r);
      start_span.span_y      = item.center_y;
      start_span.span_length = {r, 1'b0};
      start_span.span_color  = item.fill_color;
    end
  end

endmodule

[src/fcsg_step.sv]
// ----------------------------------------------------------------------------
// fcsg_step
// Request walk: from the held circle state, find the next non-empty span.
// ----------------------------------------------------------------------------
module fcsg_step
  import fcsg_pkg::*;
(
  input  circ_state_t cur,
  output circ_state_t nxt,
  output out_item_t   span
);

  radius_t          i;
  radius_t          x;
  radius_t          x_dec;
  sq_t              xsq_dec;
  radius_t          x_far;
  sq_t              xsq_far;
  logic [SQ_BITS:0] dsum;
  logic             far;
  logic             outer_fire;
  len_t             outer_len;
  coord_t           outer_x;

  assign i          = cur.row_step;
  assign x          = cur.col_ext;
  assign x_dec      = (x != '0) ? x - 1'b1 : x;
  assign xsq_dec    = (x != '0) ? cur.xsq - SQ_BITS'({x, 1'b0}) + SQ_BITS'(1) : cur.xsq;
  assign dsum       = {1'b0, cur.isq} + {1'b0, cur.xsq};
  assign far        = dsum > {1'b0, cur.dist_limit};
  assign outer_fire = far && (x > cur.row_limit) && (i != RADIUS_BITS'(1));
  assign x_far      = far ? x_dec : x;
  assign xsq_far    = far ? xsq_dec : cur.xsq;
  assign outer_len  = {i - 1'b1, 1'b0};
  assign outer_x    = cur.cx - COORD_BITS'(i) + COORD_BITS'(1);

  always_comb begin
    nxt  = cur;
    span = '0;
    span.span_color = cur.color;
    if (cur.active) begin
      case (cur.phase)
        PH_TEST: begin
          if (i > cur.row_limit) begin
            nxt.active = 1'b0;
          end else if (outer_fire) begin
            span.span_valid  = 1'b1;
            span.span_x      = outer_x;
            span.span_y      = cur.cy + COORD_BITS'(x);
            span.span_length = outer_len;
            nxt.phase        = PH_OUTER_HI;
          end else begin
            nxt.col_ext = x_far;
            nxt.xsq     = xsq_far;
            if (x_far == '0) begin
              nxt.active = 1'b0;
            end else begin
              span.span_valid  = 1'b1;
              span.span_x      = cur.cx - COORD_BITS'(x_far);
              span.span_y      = cur.cy + COORD_BITS'(i);
              span.span_length = {x_far, 1'b0};
              nxt.phase        = PH_INNER_HI;
            end
          end
        end
        PH_OUTER_HI: begin
          span.span_valid  = 1'b1;
          span.span_x      = outer_x;
          span.span_y      = cur.cy - COORD_BITS'(x);
          span.span_length = outer_len;
          nxt.col_ext      = x_dec;
          nxt.xsq          = xsq_dec;
          nxt.phase        = PH_INNER_LO;
        end
        PH_INNER_LO: begin
          if (x == '0) begin
            nxt.active = 1'b0;
          end else begin
            span.span_valid  = 1'b1;
            span.span_x      = cur.cx - COORD_BITS'(x);
            span.span_y      = cur.cy + COORD_BITS'(i);
            span.span_length = {x, 1'b0};
            nxt.phase        = PH_INNER_HI;
          end
        end
        PH_INNER_HI: begin
          span.span_valid  = 1'b1;
          span.span_x      = cur.cx - COORD_BITS'(x);
          span.span_y      = cur.cy - COORD_BITS'(i);
          span.span_length = {x, 1'b0};
          nxt.row_step     = i + 1'b1;
          nxt.isq          = cur.isq + SQ_BITS'({i, 1'b0}) + SQ_BITS'(1);
          nxt.phase        = PH_TEST;
        end
        default: begin
          nxt.active = 1'b0;
        end
      endcase
    end
    if (!span.span_valid) begin
      span = '0;
    end
  end

endmodule

[src/filled_circle_span_generator_unit.sv]
// ----------------------------------------------------------------------------
// filled_circle_span_generator_unit
// Filled-circle command to horizontal span converter for a fill engine.
// ----------------------------------------------------------------------------
// Every accepted item yields exactly one result, one item per clock cycle
// sustained while out_stall is low. Each item passes an input register,
// then the start decode (one radius square and a constant reciprocal
// multiply for the row limit) or the span walk (one add and compare of
// the held row and column squares), into the result register. A start
// item returns the center row; each request returns the next span, or
// span_valid low with all other fields zero once the circle is done.
// ----------------------------------------------------------------------------
module filled_circle_span_generator_unit
  import fcsg_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  in_item_t    in_r;
  logic        in_vld_r;
  circ_state_t state_r;
  circ_state_t state_nxt;
  out_item_t   out_r;
  out_item_t   out_nxt;
  logic        out_vld_r;
  logic        advance;

  circ_state_t start_state;
  out_item_t   start_span;
  circ_state_t step_state;
  out_item_t   step_span;

  fcsg_setup u_setup (
    .item        (in_r),
    .start_state (start_state),
    .start_span  (start_span)
  );

  fcsg_step u_step (
    .cur  (state_r),
    .nxt  (step_state),
    .span (step_span)
  );

  assign advance   = !out_vld_r || !out_stall;
  assign in_stall  = in_vld_r && !advance;
  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  always_comb begin
    if (in_r.op == OP_START) begin
      state_nxt = start_state;
      out_nxt   = start_span;
    end else begin
      state_nxt = step_state;
      out_nxt   = step_span;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      state_r   <= '0;
    end else begin
      if (!in_stall) begin
        in_vld_r <= in_valid;
      end
      if (advance) begin
        out_vld_r <= in_vld_r;
        if (in_vld_r) begin
          state_r <= state_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_r <= in_data;
    end
    if (advance && in_vld_r) begin
      out_r <= out_nxt;
    end
  end

endmodule
